// File: hw/rtl/tsc_pkg.sv
// Package for the tension sample calibrator: codes, field widths, limits
// and the divider status type. Depends on nothing.
package tsc_pkg;

  localparam int RAW_W   = 12;
  localparam int VAL_W   = 15;
  localparam int SUM_W   = 20;
  localparam int CSUM_W  = 31;
  localparam int PASS_W  = 16;
  localparam int DIVR_W  = 16;
  localparam int LINE_W  = 3;
  localparam int SHIFT_4096 = 12;

  localparam logic [VAL_W-1:0]  VAL_MAX      = 15'h7FFF;
  localparam logic [SUM_W-1:0]  SUM_MAX      = 20'hFFFFF;
  localparam logic [CSUM_W-1:0] CAL_SUM_MAX  = 31'h7FFFFFFF;
  localparam logic [PASS_W-1:0] PASS_MAX     = 16'hFFFF;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ZERO   = 2'd1;
  localparam logic [1:0] OP_BASE   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_ZERO  = 2'd1;
  localparam logic [1:0] KIND_BASE  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_ROUNDS     = 2'd1;
  localparam logic [1:0] REG_LINES      = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hw/rtl/tsc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tsc_pkg.
module tsc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tsc_pkg::CSUM_W-1:0]  dividend,
  input  logic [tsc_pkg::DIVR_W-1:0]  divisor,
  output tsc_pkg::div_status_t        status,
  output logic [tsc_pkg::CSUM_W-1:0]  quotient
);
  import tsc_pkg::*;

  localparam int CNT_W = $clog2(CSUM_W);

  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIVR_W:0]   shifted;
  logic              fits;

  assign shifted = {rem, quotient[CSUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= !start && status.busy && (cnt == CNT_W'(CSUM_W - 1));
      if (start) begin
        status.busy <= 1'b1;
        quotient    <= dividend;
        dvs         <= divisor;
        rem         <= '0;
        cnt         <= '0;
      end else if (status.busy) begin
        // shift in one dividend bit, subtract where it fits
        if (fits) begin
          rem <= DIVR_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DIVR_W-1:0];
        end
        quotient <= {quotient[CSUM_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(CSUM_W - 1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: hw/rtl/tension_sample_calibrator_core.sv
// Top level of the tension sample calibrator: APB registers, sequencer and
// per-line storage. Depends on tsc_pkg and tsc_div.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tuser operation, s_tdata axis,line,raw
//  m_*      out  m_tvalid / m_tready    m_tuser kind, m_tdata axis,line,value,
//                                       m_tlast last of run
//  apb      in   psel/penable, pready=1 full_scale, sample_rounds, lines_cfg
//
// A start or an ignored word is handled in the idle state alone; a raw sample
// also passes the sample step. A word that closes a pass then runs each line
// through the shared divider, the multiply and the apply step; a finish runs
// each line through the divider and the apply step, with no multiply.
// Reset (synchronous, active high) clears sums, tables and calibration state.
// s_tready is high only while the sequencer is idle; a stalled result word
// holds the sequencer at its apply step, and input is still taken while the
// last result waits in the output register.
module tension_sample_calibrator_core #(
  parameter int MAX_LINES = 6,
  parameter int NUM_AXES  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // axis[0], line[3:1], raw_sample[15:4]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_axis[0], out_line[3:1], value[18:4], zeros
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsc_pkg::*;

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int AX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int LC_W  = 4;

  typedef enum logic [2:0] {
    S_IDLE, S_SAMPLE, S_DIV, S_WAIT, S_MUL, S_APPLY, S_ERR
  } state_t;

  state_t state;

  // configuration
  logic [VAL_W-1:0] full_scale;
  logic [7:0]       sample_rounds;
  logic [2:0]       lines_cfg;

  // storage
  logic [SUM_W-1:0]  line_sums [MAX_LINES];
  logic [7:0]        round_counter;
  logic [VAL_W-1:0]  zero_table [NUM_AXES][MAX_LINES];
  logic [CSUM_W-1:0] cal_sums [MAX_LINES];
  logic [PASS_W-1:0] cal_passes;
  logic              cal_active;
  logic              cal_is_base;
  logic              cal_axis;

  // work registers
  logic [IDX_W-1:0]  idx;
  logic              pass_mode;
  logic              run_axis;
  logic [RAW_W-1:0]  raw_r;
  logic [CSUM_W-1:0] quo_r;
  logic [VAL_W-1:0]  val_r;

  // output word
  logic [1:0]       out_kind;
  logic             out_axis;
  logic [LINE_W-1:0] out_line;
  logic [VAL_W-1:0] out_value;

  // divider
  logic              div_start;
  div_status_t       div_st;
  logic [CSUM_W-1:0] div_q;
  logic [CSUM_W-1:0] div_dividend;
  logic [DIVR_W-1:0] div_divisor;

  // decode
  logic             apb_wr;
  logic [LC_W-1:0]  lc;
  logic [7:0]       rounds;
  logic             s_axis;
  logic [LINE_W-1:0] s_line;
  logic             axis_ok;
  logic             idx_last;
  logic             out_free;
  logic             out_load;
  logic [SUM_W:0]   add_sum;
  logic [SUM_W-1:0] sum_sat;
  logic [7:0]       rc_next;
  logic [34:0]      product;
  logic [22:0]      scaled;
  logic [CSUM_W:0]  cal_add;
  logic [VAL_W-1:0] zero_off;
  logic [VAL_W-1:0] clamped;
  logic [AX_W-1:0]  ax_ix;

  assign pready   = 1'b1;
  assign apb_wr   = psel & penable & pwrite & pready;
  assign s_tready = (state == S_IDLE);
  assign s_axis   = s_tdata[0];
  assign s_line   = s_tdata[3:1];
  assign axis_ok  = (32'(s_axis) < NUM_AXES);
  assign out_free = !m_tvalid || m_tready;
  // load a word from the apply step (unless folding into calibration) or the error step
  assign out_load = out_free && (((state == S_APPLY) && !(pass_mode && cal_active)) ||
                                 (state == S_ERR));

  // a line count outside the supported range acts as the full width
  always_comb begin
    if (lines_cfg != 3'd0 && 32'(lines_cfg) <= MAX_LINES) begin
      lc = LC_W'(lines_cfg);
    end else begin
      lc = LC_W'(MAX_LINES);
    end
  end

  assign rounds   = (sample_rounds == 8'd0) ? 8'd1 : sample_rounds;
  assign idx_last = (LC_W'(idx) + 1'b1) == lc;
  assign add_sum  = {1'b0, line_sums[idx]} + (SUM_W + 1)'(raw_r);
  assign sum_sat  = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
  assign rc_next  = round_counter + 1'b1;
  assign product  = 35'(quo_r[SUM_W-1:0]) * 35'(full_scale);
  assign scaled   = product[34:SHIFT_4096];
  assign cal_add  = {1'b0, cal_sums[idx]} + (CSUM_W + 1)'(val_r);
  assign ax_ix    = AX_W'(run_axis);
  assign zero_off = zero_table[ax_ix][idx];
  assign clamped  = (val_r > zero_off) ? (val_r - zero_off) : '0;

  assign div_dividend = pass_mode ? CSUM_W'(line_sums[idx]) : cal_sums[idx];
  assign div_divisor  = pass_mode ? DIVR_W'(rounds) : cal_passes;
  assign div_start    = (state == S_DIV);

  assign m_tdata = {5'b0, out_value, out_line, out_axis};
  assign m_tuser = out_kind;

  // APB read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_FULL_SCALE: prdata = 32'(full_scale);
      REG_ROUNDS:     prdata = 32'(sample_rounds);
      REG_LINES:      prdata = 32'(lines_cfg);
      default:        prdata = '0;
    endcase
  end

  tsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      full_scale    <= 15'd200;
      sample_rounds <= 8'd20;
      lines_cfg     <= 3'd6;
      round_counter <= '0;
      cal_passes    <= '0;
      cal_active    <= 1'b0;
      cal_is_base   <= 1'b0;
      cal_axis      <= 1'b0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < MAX_LINES; i++) begin
        line_sums[i] <= '0;
        cal_sums[i]  <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
          zero_table[a][i] <= '0;
        end
      end
    end else begin
      if (apb_wr) begin
        unique case (paddr[3:2])
          REG_FULL_SCALE: full_scale    <= pwdata[VAL_W-1:0];
          REG_ROUNDS:     sample_rounds <= pwdata[7:0];
          REG_LINES:      lines_cfg     <= pwdata[2:0];
          default:        ;
        endcase
      end

      // raise the output word on a load, drop it once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            raw_r <= s_tdata[15:4];
            idx   <= (s_tuser == OP_FINISH) ? '0 : IDX_W'(s_line);
            case (s_tuser) inside
              OP_FINISH: begin
                run_axis  <= cal_axis;
                pass_mode <= 1'b0;
                if (cal_active) begin
                  if (cal_passes == '0) begin
                    state <= S_ERR;
                  end else begin
                    state <= S_DIV;
                  end
                end
              end
              OP_ZERO, OP_BASE: begin
                if (axis_ok) begin
                  cal_active  <= 1'b1;
                  cal_is_base <= (s_tuser == OP_BASE);
                  cal_axis    <= s_axis;
                end
              end
              default: begin
                run_axis  <= s_axis;
                pass_mode <= 1'b1;
                if (axis_ok && LC_W'(s_line) < lc) begin
                  state <= S_SAMPLE;
                end
              end
            endcase
          end
        end

        S_SAMPLE: begin
          if (idx_last && rc_next >= rounds) begin
            if (cal_active && cal_axis != run_axis) begin
              // pass for the other axis during calibration: discard it
              round_counter <= '0;
              for (int i = 0; i < MAX_LINES; i++) begin
                line_sums[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              line_sums[idx] <= sum_sat;
              round_counter  <= rc_next;
              idx            <= '0;
              state          <= S_DIV;
            end
          end else begin
            line_sums[idx] <= sum_sat;
            if (idx_last) begin
              round_counter <= rc_next;
            end
            state <= S_IDLE;
          end
        end

        S_DIV: begin
          state <= S_WAIT;
        end

        S_WAIT: begin
          if (div_st.done) begin
            quo_r <= div_q;
            if (pass_mode) begin
              state <= S_MUL;
            end else begin
              val_r <= (div_q > CSUM_W'(VAL_MAX)) ? VAL_MAX : div_q[VAL_W-1:0];
              state <= S_APPLY;
            end
          end
        end

        S_MUL: begin
          val_r <= (scaled > 23'(VAL_MAX)) ? VAL_MAX : scaled[VAL_W-1:0];
          state <= S_APPLY;
        end

        S_APPLY: begin
          if ((pass_mode && cal_active) || out_free) begin
            if (pass_mode && cal_active) begin
              cal_sums[idx] <= cal_add[CSUM_W] ? CAL_SUM_MAX : cal_add[CSUM_W-1:0];
            end else begin
              out_axis  <= run_axis;
              out_line  <= LINE_W'(idx);
              m_tlast   <= idx_last;
              if (pass_mode) begin
                out_kind  <= KIND_VALUE;
                out_value <= clamped;
              end else if (cal_is_base) begin
                out_kind  <= KIND_BASE;
                out_value <= clamped;
              end else begin
                out_kind  <= KIND_ZERO;
                out_value <= val_r;
                zero_table[ax_ix][idx] <= val_r;
              end
            end
            if (idx_last) begin
              state <= S_IDLE;
              if (pass_mode) begin
                round_counter <= '0;
                for (int i = 0; i < MAX_LINES; i++) begin
                  line_sums[i] <= '0;
                end
                if (cal_active && cal_passes != PASS_MAX) begin
                  cal_passes <= cal_passes + 1'b1;
                end
              end else begin
                cal_passes <= '0;
                cal_active <= 1'b0;
                for (int i = 0; i < MAX_LINES; i++) begin
                  cal_sums[i] <= '0;
                end
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV;
            end
          end
        end

        S_ERR: begin
          if (out_free) begin
            out_kind   <= KIND_ERR;
            out_axis   <= cal_axis;
            out_line   <= '0;
            out_value  <= '0;
            m_tlast    <= 1'b1;
            cal_passes <= '0;
            cal_active <= 1'b0;
            for (int i = 0; i < MAX_LINES; i++) begin
              cal_sums[i] <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/tsc_checker.sv
// Port-level checks for the tension sample calibrator, bound to the top.
// Depends on tsc_pkg and tension_sample_calibrator_core.
module tsc_checker #(
  parameter int MAX_LINES = 6
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast,
  input logic        pready
);
  import tsc_pkg::*;

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // error word is a lone word on line zero with no value
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERR |-> m_tlast && m_tdata[18:1] == '0)
    else $error("malformed calibration error word");

  // reported line stays within the line table and the padding bits stay zero
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[3:1]) < MAX_LINES && m_tdata[23:19] == '0)
    else $error("result line out of range or padding set");

  a_ready: assert property (@(posedge clk) pready)
    else $error("register port stalled");
endmodule

bind tension_sample_calibrator_core tsc_checker #(.MAX_LINES(MAX_LINES)) u_tsc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .pready   (pready)
);
